FILE: rtl/core/pixel_quantize_bit_packer_top_macros.svh
// Assertion macros shared by the pixel quantizer and bit packer RTL.
`ifndef PIXEL_QUANTIZE_BIT_PACKER_TOP_MACROS_SVH
`define PIXEL_QUANTIZE_BIT_PACKER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PQBP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PQBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/pqbp_pkg.sv
// Shared types, constants and functions of the pixel quantizer and bit packer.
package pqbp_pkg;

  localparam int unsigned PixW       = 8;
  localparam int unsigned LvlW       = 8;
  localparam int unsigned CodeW      = 8;
  localparam int unsigned WidthW     = 4;
  localparam int unsigned ByteBits   = 8;
  localparam int unsigned QueueDepth = 2;
  localparam logic [LvlW-1:0] MaxLevelRst = 8'd255;

  // One quantized pixel on its way from the front end to the packer.
  typedef struct packed {
    logic [CodeW-1:0]  code;
    logic [WidthW-1:0] width;
    logic              last;
  } quant_entry_t;

  // Code width is the position of the leading one plus one, and one bit for levels 0 and 1.
  function automatic logic [WidthW-1:0] code_width(input logic [LvlW-1:0] lvl);
    logic [WidthW-1:0] w;
    w = WidthW'(1);
    for (int i = 1; i < int'(LvlW); i++) begin
      if (lvl[i]) begin
        w = WidthW'(i + 1);
      end
    end
    return w;
  endfunction

  // floor(pixel * lvl / 255). For p = pixel * lvl, (p + (p >> 8) + 1) >> 8 equals p / 255.
  function automatic logic [CodeW-1:0] quantize(input logic [PixW-1:0] pixel,
                                                input logic [LvlW-1:0] lvl);
    logic [15:0] prod;
    logic [15:0] sum;
    prod = 16'(pixel) * 16'(lvl);
    sum  = prod + {8'h00, prod[15:8]} + 16'd1;
    return sum[15:8];
  endfunction

endpackage

FILE: rtl/core/pqbp_if.sv
// Valid/ready channel interfaces for pixel requests and packed byte results.
interface pqbp_in_if;
  logic                       valid;
  logic                       ready;
  logic [pqbp_pkg::PixW-1:0]  pixel;
  logic                       last_pixel;

  modport source (output valid, output pixel, output last_pixel, input ready);
  modport sink   (input valid, input pixel, input last_pixel, output ready);
endinterface

interface pqbp_out_if;
  logic                          valid;
  logic                          ready;
  logic [pqbp_pkg::ByteBits-1:0] packed_byte;
  logic                          last_byte;

  modport source (output valid, output packed_byte, output last_byte, input ready);
  modport sink   (input valid, input packed_byte, input last_byte, output ready);
endinterface

FILE: rtl/core/pixel_quantize_bit_packer_top.sv
// Top level of the pixel quantizer and MSB-first variable-width bit packer.
//
// Pixel requests arrive on in_if (valid/ready): an 8-bit gray pixel and a last flag.
// Each pixel is quantized to floor(pixel * max_level / 255) and packed MSB first
// as a code of floor(log2(max_level)) + 1 bits (one bit for levels 0 and 1).
// Completed bytes leave on out_if (valid/ready); the last pixel flushes a partial
// byte with zero padding and marks the final byte with last_byte.
// cfg_we/cfg_wdata write max_level; write it only while no request is in flight.
// A byte passes through the queue and then the output register: the edge that accepts
// the request completing it writes the queue, and the pop from the queue loads the output.
// Throughput: one pixel per cycle while the receiver keeps up. A pixel that yields
// two bytes holds the packer while the second byte drains.
// When the receiver stalls, the output register holds its byte and the queue of
// QUEUE_DEPTH entries fills, after which in_if.ready drops.
// Reset (rst_n low, synchronous) empties the queue and the packer and sets max_level
// to 255; no result is pending after reset.
module pixel_quantize_bit_packer_top #(
  parameter int unsigned QUEUE_DEPTH = pqbp_pkg::QueueDepth
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [pqbp_pkg::LvlW-1:0] cfg_wdata,
  pqbp_in_if.sink                   in_if,
  pqbp_out_if.source                out_if
);

  logic                   q_push;
  logic                   q_full;
  logic                   q_pop;
  logic                   q_empty;
  pqbp_pkg::quant_entry_t q_wr_entry;
  pqbp_pkg::quant_entry_t q_rd_entry;

  pqbp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_if     (in_if),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_wr_entry)
  );

  pqbp_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (q_wr_entry),
    .full     (q_full),
    .pop      (q_pop),
    .rd_entry (q_rd_entry),
    .empty    (q_empty)
  );

  pqbp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_entry (q_rd_entry),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .out_if   (out_if)
  );

endmodule

FILE: rtl/core/pqbp_front.sv
// Front end: holds the level register, accepts pixels, quantizes them and sizes the codes.
module pqbp_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [pqbp_pkg::LvlW-1:0]  cfg_wdata,
  pqbp_in_if.sink                    in_if,
  input  logic                       q_full,
  output logic                       q_push,
  output pqbp_pkg::quant_entry_t     q_entry
);

  logic [pqbp_pkg::LvlW-1:0] max_level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_level_r <= pqbp_pkg::MaxLevelRst;
    end else if (cfg_we) begin
      max_level_r <= cfg_wdata;
    end
  end

  assign in_if.ready = !q_full;
  assign q_push      = in_if.valid && !q_full;

  always_comb begin
    q_entry.code  = pqbp_pkg::quantize(in_if.pixel, max_level_r);
    q_entry.width = pqbp_pkg::code_width(max_level_r);
    q_entry.last  = in_if.last_pixel;
  end

endmodule

FILE: rtl/core/pqbp_queue.sv
// Short queue of quantized codes between the front end and the packer.
`include "pixel_quantize_bit_packer_top_macros.svh"

module pqbp_queue #(
  parameter int unsigned Depth = pqbp_pkg::QueueDepth
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  pqbp_pkg::quant_entry_t wr_entry,
  output logic                   full,
  input  logic                   pop,
  output pqbp_pkg::quant_entry_t rd_entry,
  output logic                   empty
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  pqbp_pkg::quant_entry_t entries_r [Depth];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] rd_ptr_r;
  logic [CntW-1:0] count_r;
  logic [CntW-1:0] count_nxt;

  assign full     = (count_r == FullCnt);
  assign empty    = (count_r == '0);
  assign rd_entry = entries_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= wr_entry;
    end
  end

  `PQBP_ASSERT_SAME(a_no_pop_empty, clk, rst_n, pop, count_r != '0, "queue popped while empty")
  `PQBP_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_r <= FullCnt, "queue count overflow")

endmodule

FILE: rtl/core/pqbp_back.sv
// Back end: packs codes MSB first into bytes and drives the result channel.
`include "pixel_quantize_bit_packer_top_macros.svh"

module pqbp_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pqbp_pkg::quant_entry_t rd_entry,
  input  logic                   q_empty,
  output logic                   q_pop,
  pqbp_out_if.source             out_if
);

  localparam int unsigned BB = pqbp_pkg::ByteBits;

  logic [BB-1:0] accum_r;
  logic [2:0]    off_r;
  logic          out_valid_r;
  logic [BB-1:0] out_byte_r;
  logic          out_last_r;
  logic          pend_valid_r;
  logic [BB-1:0] pend_byte_r;

  logic            slot_free;
  logic [3:0]      total;
  logic [2*BB-1:0] win;
  logic            byte_done;
  logic [BB-1:0]   acc_nxt;
  logic [2:0]      off_nxt;
  logic            flush;
  logic            first_valid;
  logic [BB-1:0]   first_byte;
  logic            first_last;
  logic            second_valid;

  assign slot_free = !out_valid_r || out_if.ready;
  assign q_pop     = !q_empty && !pend_valid_r && slot_free;

  // The code lands in a two-byte window right after the bits already held.
  always_comb begin
    total     = {1'b0, off_r} + rd_entry.width;
    win       = {accum_r, {BB{1'b0}}}
              | ((2*BB)'(rd_entry.code) << (5'd16 - 5'(total)));
    byte_done = total[3];
    acc_nxt   = byte_done ? win[BB-1:0] : win[2*BB-1:BB];
    off_nxt   = total[2:0];
    flush     = rd_entry.last && (off_nxt != 3'd0);
    first_valid  = byte_done || flush;
    first_byte   = byte_done ? win[2*BB-1:BB] : acc_nxt;
    second_valid = byte_done && flush;
    first_last   = rd_entry.last && !second_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r      <= '0;
      off_r        <= '0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        accum_r <= rd_entry.last ? '0 : acc_nxt;
        off_r   <= rd_entry.last ? 3'd0 : off_nxt;
      end
      if (slot_free) begin
        if (pend_valid_r) begin
          out_valid_r  <= 1'b1;
          pend_valid_r <= 1'b0;
        end else begin
          out_valid_r  <= q_pop && first_valid;
          pend_valid_r <= q_pop && second_valid;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (pend_valid_r) begin
        out_byte_r <= pend_byte_r;
        out_last_r <= 1'b1;
      end else begin
        out_byte_r  <= first_byte;
        out_last_r  <= first_last;
        pend_byte_r <= acc_nxt;
      end
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.packed_byte = out_byte_r;
  assign out_if.last_byte   = out_last_r;

  `PQBP_ASSERT_SAME(a_pend_behind_out, clk, rst_n, pend_valid_r, out_valid_r, "pending byte without output byte")
  `PQBP_ASSERT_NEXT(a_last_clears, clk, rst_n, q_pop && rd_entry.last, (off_r == 3'd0) && (accum_r == '0), "packer not cleared after last pixel")

endmodule

FILE: sim/tb_pixel_quantize_bit_packer_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the pixel quantizer and MSB-first bit packer top level.
module tb_pixel_quantize_bit_packer_top;

  localparam int unsigned LATENCY_CYCLES = 8;
  localparam int unsigned DRAIN_LIMIT    = 20000;
  localparam int unsigned RANDOM_ITEMS   = 650;
  localparam int unsigned GAP_MAX        = 13;
  localparam int unsigned HOLD_CYCLES    = 60;
  localparam int unsigned PRESSURE_PHASE = 3;

  typedef enum logic [1:0] {
    OP_CFG,
    OP_PREDICT,
    OP_NONE,
    OP_ONE
  } row_op_t;

  typedef struct packed {
    row_op_t                       op;
    logic [pqbp_pkg::PixW-1:0]     value;
    logic                          last;
    logic [pqbp_pkg::ByteBits-1:0] exp_data;
    logic                          exp_last;
  } stim_row_t;

  typedef struct packed {
    logic [pqbp_pkg::ByteBits-1:0] data;
    logic                          last;
  } packed_exp_t;

  // Directed requests; OP_ONE rows carry their byte by hand, OP_NONE rows expect none.
  localparam stim_row_t DIRECTED [30] = '{
    '{OP_ONE,     8'h00, 1'b0, 8'h00, 1'b0},
    '{OP_ONE,     8'hFF, 1'b0, 8'hFF, 1'b0},
    '{OP_ONE,     8'h80, 1'b1, 8'h80, 1'b1},
    '{OP_ONE,     8'h01, 1'b1, 8'h01, 1'b1},
    '{OP_CFG,     8'h00, 1'b0, 8'h00, 1'b0},
    '{OP_NONE,    8'hFF, 1'b0, 8'h00, 1'b0},
    '{OP_NONE,    8'hFF, 1'b0, 8'h00, 1'b0},
    '{OP_ONE,     8'hFF, 1'b1, 8'h00, 1'b1},
    '{OP_CFG,     8'h01, 1'b0, 8'h00, 1'b0},
    '{OP_ONE,     8'hFF, 1'b1, 8'h80, 1'b1},
    '{OP_ONE,     8'hFE, 1'b1, 8'h00, 1'b1},
    '{OP_CFG,     8'h07, 1'b0, 8'h00, 1'b0},
    '{OP_PREDICT, 8'hFF, 1'b0, 8'h00, 1'b0},
    '{OP_PREDICT, 8'h00, 1'b0, 8'h00, 1'b0},
    '{OP_PREDICT, 8'hFF, 1'b0, 8'h00, 1'b0},
    '{OP_PREDICT, 8'h92, 1'b1, 8'h00, 1'b0},
    '{OP_CFG,     8'h0F, 1'b0, 8'h00, 1'b0},
    '{OP_PREDICT, 8'hFF, 1'b0, 8'h00, 1'b0},
    '{OP_PREDICT, 8'h7F, 1'b0, 8'h00, 1'b0},
    '{OP_PREDICT, 8'h33, 1'b0, 8'h00, 1'b0},
    '{OP_CFG,     8'h64, 1'b0, 8'h00, 1'b0},
    '{OP_PREDICT, 8'hAB, 1'b0, 8'h00, 1'b0},
    '{OP_PREDICT, 8'h10, 1'b1, 8'h00, 1'b0},
    '{OP_CFG,     8'h80, 1'b0, 8'h00, 1'b0},
    '{OP_PREDICT, 8'hFF, 1'b1, 8'h00, 1'b0},
    '{OP_CFG,     8'h02, 1'b0, 8'h00, 1'b0},
    '{OP_PREDICT, 8'h80, 1'b0, 8'h00, 1'b0},
    '{OP_PREDICT, 8'hFF, 1'b1, 8'h00, 1'b0},
    '{OP_CFG,     8'hFF, 1'b0, 8'h00, 1'b0},
    '{OP_PREDICT, 8'h5A, 1'b1, 8'h00, 1'b0}
  };

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      cfg_we;
  logic [pqbp_pkg::LvlW-1:0] cfg_wdata;

  pqbp_in_if  in_bus ();
  pqbp_out_if out_bus ();

  pixel_quantize_bit_packer_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_if     (in_bus),
    .out_if    (out_bus)
  );

  // Shadow copy of the block state, owned by the monitor process.
  logic [pqbp_pkg::LvlW-1:0]     model_level;
  logic [pqbp_pkg::ByteBits-1:0] model_accum;
  int unsigned                   model_fill;

  packed_exp_t byte_q[$];
  stim_row_t   pending_rows[$];
  int unsigned err_count     = 0;
  int unsigned send_gap_max  = GAP_MAX;
  int unsigned recv_gap_max  = GAP_MAX;
  int unsigned hold_req      = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  function automatic int unsigned width_of(input logic [pqbp_pkg::LvlW-1:0] lvl);
    return (lvl < 2) ? 1 : $clog2(int'(lvl) + 1);
  endfunction

  // Quantizes one pixel, packs its code and optionally queues the bytes it completes.
  task automatic pack_pixel(input logic [pqbp_pkg::PixW-1:0] pix, input logic last_in,
                            input bit keep);
    int unsigned w;
    int unsigned code;
    int unsigned total;
    int unsigned rem;
    logic [15:0] wide;
    packed_exp_t res[$];
    w     = width_of(model_level);
    code  = (int'(pix) * int'(model_level)) / 255;
    total = model_fill + w;
    if (total >= pqbp_pkg::ByteBits) begin
      rem = total - pqbp_pkg::ByteBits;
      res.push_back('{data: model_accum | 8'(code >> rem), last: 1'b0});
      // Only the low rem bits survive the shift into the top of the byte.
      wide        = 16'(code) << (pqbp_pkg::ByteBits - rem);
      model_accum = wide[7:0];
      model_fill  = rem;
    end else begin
      wide        = 16'(code) << (pqbp_pkg::ByteBits - total);
      model_accum = model_accum | wide[7:0];
      model_fill  = total;
    end
    if (last_in) begin
      if (model_fill != 0) begin
        res.push_back('{data: model_accum, last: 1'b0});
      end
      res[res.size() - 1].last = 1'b1;
      model_accum = '0;
      model_fill  = 0;
    end
    if (keep) begin
      foreach (res[i]) byte_q.push_back(res[i]);
    end
  endtask

  always @(posedge clk) begin
    stim_row_t   row;
    packed_exp_t want;
    if (!rst_n) begin
      model_level = pqbp_pkg::MaxLevelRst;
      model_accum = '0;
      model_fill  = 0;
    end else begin
      if (cfg_we) begin
        model_level = cfg_wdata;
      end
      if (in_bus.valid && in_bus.ready) begin
        row = pending_rows.pop_front();
        case (row.op)
          OP_ONE: begin
            byte_q.push_back('{data: row.exp_data, last: row.exp_last});
            pack_pixel(in_bus.pixel, in_bus.last_pixel, 1'b0);
          end
          OP_NONE: pack_pixel(in_bus.pixel, in_bus.last_pixel, 1'b0);
          default: pack_pixel(in_bus.pixel, in_bus.last_pixel, 1'b1);
        endcase
      end
      if (out_bus.valid && out_bus.ready) begin
        if (byte_q.size() == 0) begin
          report_mismatch("byte with nothing expected", out_bus.packed_byte, 0);
        end else begin
          want = byte_q.pop_front();
          if (out_bus.packed_byte !== want.data) begin
            report_mismatch("packed_byte", out_bus.packed_byte, want.data);
          end
          if (out_bus.last_byte !== want.last) begin
            report_mismatch("last_byte", out_bus.last_byte, want.last);
          end
        end
      end
    end
  end

  // Result side: random stalls per byte, with one long hold-off on request.
  initial begin
    int unsigned stall;
    out_bus.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req > 0) begin
        stall    = hold_req;
        hold_req = 0;
      end else begin
        stall = $urandom_range(recv_gap_max, 0);
      end
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
    end
  end

  task automatic offer(input stim_row_t row, input int unsigned gap);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.pixel      <= row.value;
    in_bus.last_pixel <= row.last;
    pending_rows.push_back(row);
    do @(posedge clk); while (!in_bus.ready);
  endtask

  // Stops requests and waits until every expected byte has come, plus the pipeline depth.
  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    for (int n = 0; byte_q.size() != 0 && n < DRAIN_LIMIT; n++) @(posedge clk);
    repeat (LATENCY_CYCLES) @(posedge clk);
  endtask

  task automatic set_level(input logic [pqbp_pkg::LvlW-1:0] lvl);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= lvl;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int unsigned items;
    int unsigned phase;
    int unsigned phase_len;
    bit          quiet;
    bit          end_last;
    logic [7:0]  lvl;
    stim_row_t   row;
    in_bus.valid      <= 1'b0;
    in_bus.pixel      <= '0;
    in_bus.last_pixel <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    rst_n             <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].op == OP_CFG) begin
        set_level(DIRECTED[i].value);
      end else begin
        offer(DIRECTED[i], $urandom_range(GAP_MAX, 0));
      end
    end

    items = 0;
    phase = 0;
    while (items < RANDOM_ITEMS) begin
      if (phase == PRESSURE_PHASE) begin
        // Full-width codes give a byte per request so the queue fills under the hold-off.
        set_level(8'hFF);
      end else if (phase == 0 || $urandom_range(1, 0) == 1) begin
        case ($urandom_range(5, 0))
          0:       lvl = 8'h00;
          1:       lvl = 8'h01;
          2:       lvl = 8'hFF;
          3:       lvl = 8'h80;
          default: lvl = 8'($urandom_range(255, 0));
        endcase
        set_level(lvl);
      end
      quiet        = ($urandom_range(4, 0) == 0) || (phase == PRESSURE_PHASE);
      send_gap_max = quiet ? 0 : GAP_MAX;
      recv_gap_max = quiet ? 0 : GAP_MAX;
      if (phase == PRESSURE_PHASE) begin
        hold_req = HOLD_CYCLES;
      end
      phase_len = $urandom_range(60, 8);
      end_last  = ($urandom_range(1, 0) == 1);
      for (int k = 0; k < int'(phase_len); k++) begin
        row.op       = OP_PREDICT;
        row.exp_data = '0;
        row.exp_last = 1'b0;
        case ($urandom_range(7, 0))
          0:       row.value = 8'h00;
          1:       row.value = 8'hFF;
          default: row.value = 8'($urandom_range(255, 0));
        endcase
        row.last = ((k == int'(phase_len) - 1) && end_last) || ($urandom_range(15, 0) == 0);
        offer(row, $urandom_range(send_gap_max, 0));
        items++;
      end
      if ($urandom_range(3, 0) == 0) begin
        drain();
      end
      phase++;
    end

    recv_gap_max = GAP_MAX;
    drain();
    repeat (LATENCY_CYCLES) @(posedge clk);
    if (byte_q.size() != 0) begin
      report_mismatch("bytes never delivered", 0, byte_q.size());
    end
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
